/* rtl/qslp_pkg.sv */
// Shared types and constants for the quaternion slerp pipeline.
`timescale 1ns / 1ps
`default_nettype none
package qslp_pkg;

  localparam int CORDIC_STEPS = 30;

  localparam logic [30:0] Q_ONE       = 31'h4000_0000;
  localparam logic [31:0] SIN_EPS     = 32'd107374;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] CORDIC_K    = 32'd652032874;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] first_w;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] second_w;
    logic        [30:0] blend;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
  } out_t;

  typedef struct packed {
    logic signed [65:0] num;
    logic        [31:0] den;
    logic               zero;
  } div_in_t;

endpackage
`default_nettype wire

/* rtl/qslp_delay.sv */
// Enabled shift line that carries side data alongside the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module qslp_delay #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire              clk,
  input  wire              en,
  input  wire  [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] data_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      data_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        data_r[i] <= data_r[i-1];
      end
    end
  end

  assign dout = data_r[DEPTH-1];

endmodule
`default_nettype wire

/* rtl/qslp_isqrt.sv */
// Pipelined integer square root, one root bit per stage, 32 stages.
`timescale 1ns / 1ps
`default_nettype none
module qslp_isqrt (
  input  wire         clk,
  input  wire         en,
  input  wire  [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] v_r   [32];
  logic [63:0] res_r [32];

  for (genvar k = 0; k < 32; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] v_in, r_in;
    logic [64:0] trial;

    if (k == 0) begin : g_first
      assign v_in = rad;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_r[k-1];
      assign r_in = res_r[k-1];
    end

    assign trial = {1'b0, r_in} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, v_in} >= trial) begin
          v_r[k]   <= v_in - trial[63:0];
          res_r[k] <= (r_in >> 1) + BIT;
        end else begin
          v_r[k]   <= v_in;
          res_r[k] <= r_in >> 1;
        end
      end
    end
  end

  assign root = res_r[31][31:0];

endmodule
`default_nettype wire

/* rtl/qslp_cordic_vec.sv */
// Pipelined CORDIC vectoring: angle of (x, y) for y >= 0, clamped to [0, pi].
`timescale 1ns / 1ps
`default_nettype none
module qslp_cordic_vec (
  input  wire                clk,
  input  wire                en,
  input  wire  [30:0]        y_in,
  input  wire  signed [31:0] x_in,
  output logic [31:0]        theta
);

  localparam int N = qslp_pkg::CORDIC_STEPS;
  localparam logic signed [35:0] PI_S = $signed({4'b0, qslp_pkg::PI_Q30});

  logic signed [35:0] x_r [N+1];
  logic signed [35:0] y_r [N+1];
  logic signed [35:0] z_r [N+1];

  // turn a vector in the left half plane by -pi/2 first
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in < 0) begin
        x_r[0] <= $signed({5'b0, y_in});
        y_r[0] <= -36'(x_in);
        z_r[0] <= $signed({4'b0, qslp_pkg::HALF_PI_Q30});
      end else begin
        x_r[0] <= 36'(x_in);
        y_r[0] <= $signed({5'b0, y_in});
        z_r[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_iter
    localparam logic signed [35:0] ANG = $signed({4'b0, qslp_pkg::ATAN_TAB[k]});
    logic signed [35:0] dx, dy;

    assign dx = y_r[k] >>> k;
    assign dy = x_r[k] >>> k;

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[k][35]) begin
          x_r[k+1] <= x_r[k] - dx;
          y_r[k+1] <= y_r[k] + dy;
          z_r[k+1] <= z_r[k] - ANG;
        end else begin
          x_r[k+1] <= x_r[k] + dx;
          y_r[k+1] <= y_r[k] - dy;
          z_r[k+1] <= z_r[k] + ANG;
        end
      end
    end
  end

  assign theta = z_r[N][35]   ? '0 :
                 (z_r[N] > PI_S) ? qslp_pkg::PI_Q30 : z_r[N][31:0];

endmodule
`default_nettype wire

/* rtl/qslp_cordic_sin.sv */
// Pipelined CORDIC rotation giving the sine of an angle in [0, pi].
`timescale 1ns / 1ps
`default_nettype none
module qslp_cordic_sin (
  input  wire                clk,
  input  wire                en,
  input  wire  [31:0]        ang,
  output logic signed [31:0] sine
);

  localparam int N = qslp_pkg::CORDIC_STEPS;

  logic signed [35:0] x_r [N+1];
  logic signed [35:0] y_r [N+1];
  logic signed [35:0] z_r [N+1];
  logic [31:0] za, zf;

  // fold the second quadrant onto the first
  assign za = (ang > qslp_pkg::PI_Q30) ? qslp_pkg::PI_Q30 : ang;
  assign zf = (za > qslp_pkg::HALF_PI_Q30) ? qslp_pkg::PI_Q30 - za : za;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= $signed({4'b0, qslp_pkg::CORDIC_K});
      y_r[0] <= '0;
      z_r[0] <= $signed({4'b0, zf});
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_iter
    localparam logic signed [35:0] ANG = $signed({4'b0, qslp_pkg::ATAN_TAB[k]});
    logic signed [35:0] dx, dy;

    assign dx = y_r[k] >>> k;
    assign dy = x_r[k] >>> k;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[k][35]) begin
          x_r[k+1] <= x_r[k] - dx;
          y_r[k+1] <= y_r[k] + dy;
          z_r[k+1] <= z_r[k] - ANG;
        end else begin
          x_r[k+1] <= x_r[k] + dx;
          y_r[k+1] <= y_r[k] - dy;
          z_r[k+1] <= z_r[k] + ANG;
        end
      end
    end
  end

  assign sine = y_r[N][31:0];

endmodule
`default_nettype wire

/* rtl/qslp_div.sv */
// Pipelined signed divide, truncating toward zero, saturated to 32 bits.
`timescale 1ns / 1ps
`default_nettype none
module qslp_div (
  input  wire                     clk,
  input  wire                     en,
  input  wire  qslp_pkg::div_in_t din,
  output logic signed [31:0]      quo_r
);

  logic [65:0] mag_r;
  logic [31:0] dena_r;
  logic        nega_r, zeroa_r;

  logic [31:0] rem_r  [33];
  logic [31:0] lo_r   [33];
  logic [31:0] q_r    [33];
  logic [31:0] den_r  [33];
  logic        neg_r  [33];
  logic        ovf_r  [33];
  logic        zero_r [33];

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= din.num[65] ? 66'(-din.num) : 66'(din.num);
      nega_r  <= din.num[65];
      dena_r  <= din.den;
      zeroa_r <= din.zero;
    end
  end

  // quotient of 2^32 or more saturates; otherwise the high half starts the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0]  <= mag_r[65:32] >= {2'b0, dena_r};
      rem_r[0]  <= mag_r[63:32];
      lo_r[0]   <= mag_r[31:0];
      q_r[0]    <= '0;
      den_r[0]  <= dena_r;
      neg_r[0]  <= nega_r;
      zero_r[0] <= zeroa_r;
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_iter
    logic [32:0] rem2, diff;

    assign rem2 = {rem_r[k], lo_r[k][31]};
    assign diff = rem2 - {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem2 >= {1'b0, den_r[k]}) begin
          rem_r[k+1] <= diff[31:0];
          q_r[k+1]   <= {q_r[k][30:0], 1'b1};
        end else begin
          rem_r[k+1] <= rem2[31:0];
          q_r[k+1]   <= {q_r[k][30:0], 1'b0};
        end
        lo_r[k+1]   <= {lo_r[k][30:0], 1'b0};
        den_r[k+1]  <= den_r[k];
        neg_r[k+1]  <= neg_r[k];
        ovf_r[k+1]  <= ovf_r[k];
        zero_r[k+1] <= zero_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[32]) begin
        quo_r <= '0;
      end else if (!neg_r[32]) begin
        quo_r <= (ovf_r[32] || q_r[32][31]) ? 32'sh7FFF_FFFF : $signed(q_r[32]);
      end else begin
        quo_r <= (ovf_r[32] || (q_r[32] > 32'h8000_0000)) ? 32'sh8000_0000
                                                          : $signed(-q_r[32]);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/quaternion_slerp.sv */
// Throughput: one word per cycle while the output is not stalled; the pipeline
// is set by the 32-stage square roots, two 31-stage CORDIC units in series
// and the 35-stage divider.
// A stalled output word freezes every stage; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_slerp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  qslp_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output qslp_pkg::out_t       out_data
);

  localparam int LAT = 137;
  localparam logic signed [35:0] C_MAX = 36'sd1073741824;
  localparam logic signed [35:0] C_MIN = -36'sd1073741824;

  logic           en;
  logic [LAT-1:0] vld_r;

  assign out_valid = vld_r[LAT-1];
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // stage 1: capture, clamp blend
  qslp_pkg::in_t in_r;
  logic [30:0]   f1_r;
  logic [30:0]   omf1;
  logic signed [31:0] a1 [4];
  logic signed [31:0] b1 [4];

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_data;
      f1_r <= (in_data.blend > qslp_pkg::Q_ONE) ? qslp_pkg::Q_ONE : in_data.blend;
    end
  end

  assign a1[0] = in_r.first_x;
  assign a1[1] = in_r.first_y;
  assign a1[2] = in_r.first_z;
  assign a1[3] = in_r.first_w;
  assign b1[0] = in_r.second_x;
  assign b1[1] = in_r.second_y;
  assign b1[2] = in_r.second_z;
  assign b1[3] = in_r.second_w;
  assign omf1  = qslp_pkg::Q_ONE - f1_r;

  // stage 2: dot-product terms and linear blend terms
  logic signed [63:0] ab2_r [4];
  logic signed [63:0] la2_r [4];
  logic signed [63:0] lb2_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        ab2_r[i] <= 64'(a1[i]) * 64'(b1[i]);
        la2_r[i] <= 64'(a1[i]) * $signed({33'b0, omf1});
        lb2_r[i] <= 64'(b1[i]) * $signed({33'b0, f1_r});
      end
    end
  end

  // stage 3: cosine with clamp, blended vector
  logic signed [35:0] csum;
  logic signed [31:0] c3_r;
  logic signed [31:0] q3_r [4];
  logic signed [63:0] lsum [4];

  assign csum = 36'($signed(ab2_r[0][63:30])) + 36'($signed(ab2_r[1][63:30]))
              + 36'($signed(ab2_r[2][63:30])) + 36'($signed(ab2_r[3][63:30]));

  for (genvar i = 0; i < 4; i++) begin : g_lsum
    assign lsum[i] = la2_r[i] + lb2_r[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (csum > C_MAX) begin
        c3_r <= 32'(C_MAX);
      end else if (csum < C_MIN) begin
        c3_r <= 32'(C_MIN);
      end else begin
        c3_r <= csum[31:0];
      end
      for (int i = 0; i < 4; i++) begin
        q3_r[i] <= lsum[i][61:30];
      end
    end
  end

  // stage 4: squares
  logic [63:0] cc_full;
  logic [60:0] cc4_r;
  logic [63:0] qq_full [4];
  logic [60:0] qq4_r [4];

  assign cc_full = 64'(c3_r) * 64'(c3_r);
  for (genvar i = 0; i < 4; i++) begin : g_qq
    assign qq_full[i] = 64'(q3_r[i]) * 64'(q3_r[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc4_r <= cc_full[60:0];
      for (int i = 0; i < 4; i++) begin
        qq4_r[i] <= qq_full[i][62:2];
      end
    end
  end

  // stage 5: radicands
  logic [63:0] rad5_r, sum5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rad5_r <= 64'h1000_0000_0000_0000 - {3'b0, cc4_r};
      sum5_r <= 64'(qq4_r[0]) + 64'(qq4_r[1]) + 64'(qq4_r[2]) + 64'(qq4_r[3]);
    end
  end

  // stages 6..37: sine and norm
  logic [31:0] s37, n37;

  qslp_isqrt u_sqrt_sin (.clk(clk), .en(en), .rad(rad5_r), .root(s37));
  qslp_isqrt u_sqrt_nrm (.clk(clk), .en(en), .rad(sum5_r), .root(n37));

  // stages 38..68: angle
  logic [31:0] c37;
  logic [31:0] theta68;

  qslp_delay #(.WIDTH(32), .DEPTH(34)) u_dly_c (
    .clk(clk), .en(en), .din(c3_r), .dout(c37)
  );

  qslp_cordic_vec u_vec (
    .clk(clk), .en(en), .y_in(s37[30:0]), .x_in($signed(c37)), .theta(theta68)
  );

  // stage 69: weight angles
  logic [30:0] f68, omf68;
  logic [63:0] wl_full, wr_full;
  logic [31:0] wl69_r, wr69_r;

  qslp_delay #(.WIDTH(31), .DEPTH(67)) u_dly_f (
    .clk(clk), .en(en), .din(f1_r), .dout(f68)
  );

  assign omf68   = qslp_pkg::Q_ONE - f68;
  assign wl_full = {32'b0, theta68} * {33'b0, omf68};
  assign wr_full = {32'b0, theta68} * {33'b0, f68};

  always_ff @(posedge clk) begin
    if (en) begin
      wl69_r <= wl_full[61:30];
      wr69_r <= wr_full[61:30];
    end
  end

  // stages 70..100: weights
  logic signed [31:0] ls100, rs100;

  qslp_cordic_sin u_sin_l (.clk(clk), .en(en), .ang(wl69_r), .sine(ls100));
  qslp_cordic_sin u_sin_r (.clk(clk), .en(en), .ang(wr69_r), .sine(rs100));

  // stage 101: weighted components
  logic [255:0] ab100;
  logic signed [31:0] a100 [4];
  logic signed [31:0] b100 [4];
  logic signed [63:0] pa101_r [4];
  logic signed [63:0] pb101_r [4];

  qslp_delay #(.WIDTH(256), .DEPTH(99)) u_dly_ab (
    .clk(clk), .en(en),
    .din({in_r.first_x, in_r.first_y, in_r.first_z, in_r.first_w,
          in_r.second_x, in_r.second_y, in_r.second_z, in_r.second_w}),
    .dout(ab100)
  );

  for (genvar i = 0; i < 4; i++) begin : g_ab
    assign a100[i] = ab100[255 - 32 * i -: 32];
    assign b100[i] = ab100[127 - 32 * i -: 32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        pa101_r[i] <= 64'(a100[i]) * 64'(ls100);
        pb101_r[i] <= 64'(b100[i]) * 64'(rs100);
      end
    end
  end

  // stage 102: pick the linear or the angle path for the divider
  logic [31:0]  s101, n101;
  logic [127:0] q101v;
  logic         lin;
  qslp_pkg::div_in_t din102_r [4];

  qslp_delay #(.WIDTH(64), .DEPTH(64)) u_dly_sn (
    .clk(clk), .en(en), .din({s37, n37}), .dout({s101, n101})
  );

  qslp_delay #(.WIDTH(128), .DEPTH(98)) u_dly_q (
    .clk(clk), .en(en), .din({q3_r[0], q3_r[1], q3_r[2], q3_r[3]}), .dout(q101v)
  );

  assign lin = s101 < qslp_pkg::SIN_EPS;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        if (lin) begin
          din102_r[i].num  <= 66'($signed(q101v[127 - 32 * i -: 32])) <<< 29;
          din102_r[i].den  <= n101;
          din102_r[i].zero <= (n101 == '0);
        end else begin
          din102_r[i].num  <= 66'(pa101_r[i]) + 66'(pb101_r[i]);
          din102_r[i].den  <= s101;
          din102_r[i].zero <= 1'b0;
        end
      end
    end
  end

  // stages 103..137: divide and saturate
  logic signed [31:0] quo [4];

  for (genvar i = 0; i < 4; i++) begin : g_div
    qslp_div u_div (.clk(clk), .en(en), .din(din102_r[i]), .quo_r(quo[i]));
  end

  assign out_data = {quo[0], quo[1], quo[2], quo[3]};

endmodule
`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the quaternion slerp pipeline.
`timescale 1ns / 1ps
module tb;

  localparam int LATENCY = 137;
  localparam longint Q1 = 64'sd1073741824;
  localparam longint EPS = 64'sd107374;
  localparam longint HPI = 64'sd1686629713;
  localparam longint PI = 64'sd3373259426;
  localparam longint KC = 64'sd652032874;
  localparam longint CYCLE_LIMIT = 64'd2000000;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_e;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  qslp_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  qslp_pkg::out_t out_data;

  qslp_pkg::in_t pending_words[$];
  qslp_pkg::out_t expected_interp[$];
  int errors = 0;
  longint cycles = 0;
  phase_e phase = PH_FREE;
  bit hold_on = 0;
  bit pause_send = 0;
  int hold_left = 0;
  bit accepted = 0;

  quaternion_slerp dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic longint arc_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = HPI;
    end
    for (int i = 0; i < qslp_pkg::CORDIC_STEPS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (y < 0) begin
        x -= dx; y += dy; z -= longint'(qslp_pkg::ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(qslp_pkg::ATAN_TAB[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > PI) z = PI;
    return z;
  endfunction

  function automatic longint rot_sine(longint z);
    longint x, y, dx, dy;
    x = KC;
    y = 0;
    if (z > PI) z = PI;
    if (z > HPI) z = PI - z;
    for (int i = 0; i < qslp_pkg::CORDIC_STEPS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(qslp_pkg::ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(qslp_pkg::ATAN_TAB[i]);
      end
    end
    return y;
  endfunction

  function automatic qslp_pkg::out_t slerp_of(qslp_pkg::in_t w);
    longint a[4], b[4], q[4], r[4];
    longint c, s, f, n, theta, ls, rs;
    longint unsigned sum;
    qslp_pkg::out_t o;
    a = '{longint'(w.first_x), longint'(w.first_y), longint'(w.first_z),
          longint'(w.first_w)};
    b = '{longint'(w.second_x), longint'(w.second_y), longint'(w.second_z),
          longint'(w.second_w)};
    c = 0;
    for (int i = 0; i < 4; i++) c += shr(a[i] * b[i], 30);
    f = longint'({1'b0, w.blend});
    if (f > Q1) f = Q1;
    if (c > Q1) c = Q1;
    if (c < -Q1) c = -Q1;
    s = root64(longint'(Q1 * Q1 - c * c));
    if (s < EPS) begin
      sum = 0;
      for (int i = 0; i < 4; i++) begin
        q[i] = shr(a[i] * (Q1 - f) + b[i] * f, 30);
        sum += longint'(q[i] * q[i]) >> 2;
      end
      n = root64(sum);
      for (int i = 0; i < 4; i++) r[i] = (n == 0) ? 0 : (q[i] * 64'sd536870912) / n;
      if (n == 0) for (int i = 0; i < 4; i++) r[i] = 0;
    end else begin
      theta = arc_angle(s, c);
      ls = rot_sine(shr(theta * (Q1 - f), 30));
      rs = rot_sine(shr(theta * f, 30));
      for (int i = 0; i < 4; i++) r[i] = (a[i] * ls + b[i] * rs) / s;
    end
    o.out_x = clamp32(r[0]);
    o.out_y = clamp32(r[1]);
    o.out_z = clamp32(r[2]);
    o.out_w = clamp32(r[3]);
    return o;
  endfunction

  function automatic logic [31:0] rand_comp(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 2048) - 32'd1024;
    endcase
  endfunction

  function automatic qslp_pkg::in_t rand_word();
    qslp_pkg::in_t w;
    int mode, kind;
    mode = $urandom_range(0, 9);
    mode = (mode < 2) ? 0 : (mode < 8) ? 1 : (mode < 9) ? 2 : 3;
    w.first_x = rand_comp(mode); w.first_y = rand_comp(mode);
    w.first_z = rand_comp(mode); w.first_w = rand_comp(mode);
    kind = $urandom_range(0, 5);
    if (kind == 0) begin
      // near-parallel pair: drives the linear blend branch
      w.second_x = w.first_x; w.second_y = w.first_y;
      w.second_z = w.first_z; w.second_w = w.first_w;
    end else if (kind == 1) begin
      w.second_x = -w.first_x; w.second_y = -w.first_y;
      w.second_z = -w.first_z; w.second_w = -w.first_w;
    end else begin
      w.second_x = rand_comp(mode); w.second_y = rand_comp(mode);
      w.second_z = rand_comp(mode); w.second_w = rand_comp(mode);
    end
    case ($urandom_range(0, 7))
      0: w.blend = 31'($urandom());
      1: w.blend = $urandom_range(0, 1) ? 31'h0 : 31'h4000_0000;
      default: w.blend = 31'($urandom_range(0, 1073741824));
    endcase
    return w;
  endfunction

  function automatic qslp_pkg::in_t mk(logic [31:0] ax, ay, az, aw, bx, by, bz, bw,
                                       logic [30:0] f);
    qslp_pkg::in_t w;
    w.first_x = ax; w.first_y = ay; w.first_z = az; w.first_w = aw;
    w.second_x = bx; w.second_y = by; w.second_z = bz; w.second_w = bw;
    w.blend = f;
    return w;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !accepted) begin
      // hold the stalled word
    end else begin
      if (in_valid) void'(pending_words.pop_front());
      if (pending_words.size() > 0 && !pause_send &&
          !((phase == PH_SEND_IDLE || phase == PH_BOTH) &&
            $urandom_range(0, 99) < (phase == PH_BOTH ? 36 : 82))) begin
        in_valid <= 1'b1;
        in_data <= pending_words[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_on) begin
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (phase == PH_RECV_STALL || phase == PH_BOTH) begin
      out_stall <= ($urandom_range(0, 99) < (phase == PH_BOTH ? 36 : 82));
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    accepted <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) expected_interp.push_back(slerp_of(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_interp.size() == 0) begin
        $error("result word with no expectation: %h", out_data);
        errors++;
      end else begin
        qslp_pkg::out_t e;
        e = expected_interp.pop_front();
        if (e.out_x !== out_data.out_x) begin
          $error("out_x expected %0d got %0d", e.out_x, out_data.out_x); errors++;
        end
        if (e.out_y !== out_data.out_y) begin
          $error("out_y expected %0d got %0d", e.out_y, out_data.out_y); errors++;
        end
        if (e.out_z !== out_data.out_z) begin
          $error("out_z expected %0d got %0d", e.out_z, out_data.out_z); errors++;
        end
        if (e.out_w !== out_data.out_w) begin
          $error("out_w expected %0d got %0d", e.out_w, out_data.out_w); errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_interp.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    in_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1;

    // directed: identity, opposite, zero, extremes, blend clamp, orthogonal
    pending_words.push_back(mk(0, 0, 0, 32'h4000_0000, 0, 0, 0, 32'h4000_0000, 31'h2000_0000));
    pending_words.push_back(mk(0, 0, 0, 32'h4000_0000, 0, 0, 0, 32'hC000_0000, 31'h2000_0000));
    pending_words.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 31'h1000_0000));
    pending_words.push_back(mk(32'h4000_0000, 0, 0, 0, 32'hC000_0000, 0, 0, 0, 31'h2000_0000));
    pending_words.push_back(mk(32'h4000_0000, 0, 0, 0, 0, 32'h4000_0000, 0, 0, 31'h0));
    pending_words.push_back(mk(32'h4000_0000, 0, 0, 0, 0, 32'h4000_0000, 0, 0, 31'h4000_0000));
    pending_words.push_back(mk(32'h4000_0000, 0, 0, 0, 0, 32'h4000_0000, 0, 0, 31'h7FFF_FFFF));
    pending_words.push_back(mk(32'h4000_0000, 0, 0, 0, 0, 32'h4000_0000, 0, 0, 31'h2000_0000));
    pending_words.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h2000_0000));
    pending_words.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h1234_5678));
    pending_words.push_back(mk(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 31'h4000_0000));
    pending_words.push_back(mk(32'h4000_0000, 0, 0, 0, 32'h4000_0000, 32'h0000_8000, 0, 0, 31'h2000_0000));
    pending_words.push_back(mk(32'h2D41_3CCD, 32'h2D41_3CCD, 0, 0, 32'h4000_0000, 0, 0, 0, 31'h1555_5555));
    pending_words.push_back(mk(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 1, 1, 31'h0000_0001));
    drain();

    // random phases
    for (int p = 0; p < 4; p++) begin
      phase = phase_e'(p);
      for (int i = 0; i < 230; i++) pending_words.push_back(rand_word());
      if (p == 0) begin
        // long receiver hold-off while words keep coming, to back up the pipe
        repeat (20) @(posedge clk);
        @(posedge clk) hold_on = 1;
        @(posedge clk) hold_on = 0;
      end
      if (p == 2) begin
        // sender pause until the pipe empties
        repeat (60) @(posedge clk);
        pause_send = 1;
        while (in_valid || expected_interp.size() != 0) @(posedge clk);
        pause_send = 0;
      end
      drain();
    end
    phase = PH_FREE;
    for (int i = 0; i < 200; i++) pending_words.push_back(rand_word());
    drain();
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && expected_interp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
